[rtl/rational_arith_unit_assert.svh]
// Assertion macros for the rational arithmetic unit checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RATU_AP_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RATU_AP_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ratu_pkg.sv]
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
`default_nettype none
package ratu_pkg;

	localparam int NUM_W = 32;
	localparam int DEN_W = 31;
	localparam int MAG_W = 64;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_NEG = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DIVZ = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]             kind;
		logic signed [NUM_W-1:0] a_num;
		logic [DEN_W-1:0]       a_den;
		logic signed [NUM_W-1:0] b_num;
		logic [DEN_W-1:0]       b_den;
	} ratu_in_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0]       res_den;
		logic [1:0]             status;
	} ratu_out_t;

endpackage
`default_nettype wire

[rtl/ratu_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, 32x32 -> 64.
// Uses ratu_pkg for widths.
`default_nettype none
module ratu_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [ratu_pkg::NUM_W-1:0]  a,
	input  wire logic [ratu_pkg::NUM_W-1:0]  b,
	output logic                             done,
	output logic [ratu_pkg::MAG_W-1:0]       p
);
	localparam int W = ratu_pkg::NUM_W;

	logic [2*W-1:0]          acc_q;
	logic [W-1:0]            mcand_q;
	logic [$clog2(W)-1:0]    cnt_q;
	logic                    run_q;
	logic                    done_q;
	logic [W:0]              sum;

	// high half accumulates, low half holds the multiplier bits shifting out
	assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(W)'(W-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q   <= {{W{1'b0}}, b};
			mcand_q <= a;
		end else if (run_q) begin
			acc_q <= {sum, acc_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q[ratu_pkg::MAG_W-1:0];
endmodule
`default_nettype wire

[rtl/ratu_gcd.sv]
// Binary GCD, one shift or subtract per cycle. Both inputs nonzero.
// Returns the odd part of the GCD and both inputs with the shared power of two removed.
`default_nettype none
module ratu_gcd (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [ratu_pkg::MAG_W-1:0]  x,
	input  wire logic [ratu_pkg::MAG_W-1:0]  y,
	output logic                             done,
	output logic [ratu_pkg::MAG_W-1:0]       g,
	output logic [ratu_pkg::MAG_W-1:0]       mx,
	output logic [ratu_pkg::MAG_W-1:0]       my
);
	typedef enum logic [1:0] {PH_IDLE, PH_TWO, PH_ODD, PH_LOOP} ph_t;

	ph_t                        ph_q;
	logic                       done_q;
	logic [ratu_pkg::MAG_W-1:0] x_q, y_q, mx_q, my_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: if (go) ph_q <= PH_TWO;
				PH_TWO:  if (x_q[0] | y_q[0]) ph_q <= PH_ODD;
				PH_ODD:  if (x_q[0]) ph_q <= PH_LOOP;
				PH_LOOP: begin
					if (y_q == '0) begin
						ph_q   <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				if (go) begin
					x_q  <= x;
					y_q  <= y;
					mx_q <= x;
					my_q <= y;
				end
			end
			PH_TWO: begin
				// strip the common factor of two from the working pair and the copies
				if (!(x_q[0] | y_q[0])) begin
					x_q  <= x_q >> 1;
					y_q  <= y_q >> 1;
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end
			end
			PH_ODD: if (!x_q[0]) x_q <= x_q >> 1;
			PH_LOOP: begin
				if (y_q != '0) begin
					if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= y_q;
						y_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign g    = x_q;
	assign mx   = mx_q;
	assign my   = my_q;
endmodule
`default_nettype wire

[rtl/ratu_div.sv]
// Restoring divider, one quotient bit per cycle, 64 / 64.
// Uses ratu_pkg for widths. Divisor is nonzero.
`default_nettype none
module ratu_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [ratu_pkg::MAG_W-1:0]  dividend,
	input  wire logic [ratu_pkg::MAG_W-1:0]  divisor,
	output logic                             done,
	output logic [ratu_pkg::MAG_W-1:0]       q
);
	localparam int W = ratu_pkg::MAG_W;

	logic [W-1:0]         rem_q, quo_q, dsr_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic                 run_q, done_q;
	logic [W:0]           trial, diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(W)'(W-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = quo_q;
endmodule
`default_nettype wire

[rtl/rational_arith_unit.sv]
// Top level: exact rational add/sub/mul/div/negate with GCD reduction.
// Uses ratu_pkg, ratu_mul, ratu_gcd, ratu_div.
//
//  port   dir  handshake         word
//  req    in   start & !busy     ratu_in_t  (kind, a_num, a_den, b_num, b_den)
//  rsp    out  done, 1 cycle     ratu_out_t (res_num, res_den, status)
//
// Steps per item: the products (none for negate and unused kinds, two for mul/div,
// three for add/sub), the signed sum for add/sub, the start of the reduction, the
// binary GCD, the two quotient divisions, then a final check.
// Zero-denominator and divide-by-zero are answered from idle, in the cycle after start.
// A zero result skips the GCD and division units.
// Reset clears the sequencer only. The receiver cannot stall: done lasts one cycle.
`default_nettype none
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ratu_pkg::ratu_in_t  req,
	output logic               done,
	output ratu_pkg::ratu_out_t rsp
);
	localparam int MW    = ratu_pkg::MAG_W;
	localparam int NW    = ratu_pkg::NUM_W;
	localparam int DW    = ratu_pkg::DEN_W;
	localparam int CHK_W = (OPERAND_WIDTH < 32) ? OPERAND_WIDTH : 32;
	localparam logic [MW-1:0] LIM = MW'(1) << (CHK_W - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ADD, S_RED, S_GCD, S_DIV1, S_DIV2, S_CHECK
	} state_t;

	state_t          state_q;
	logic [2:0]      kind_q;
	logic            as_q, bs_q, rs_q;
	logic [NW-1:0]   am_q, bm_q;
	logic [DW-1:0]   ad_q, bd_q;
	logic [1:0]      mi_q;
	logic [MW-1:0]   rm_q, rd_q, p1_q;
	logic            done_q, mul_go_q, gcd_go_q, div_go_q;
	logic [NW-1:0]   mul_a_q, mul_b_q;
	logic [MW-1:0]   div_n_q, div_d_q;
	ratu_pkg::ratu_out_t rsp_q;

	logic            mul_done, gcd_done, div_done;
	logic [MW-1:0]   mul_p, gcd_g, gcd_mx, gcd_my, div_q;

	// incoming operand signs and magnitudes
	logic            in_as, in_bs, in_err, is_addsub, last_mul, sb_eff, ovf;
	logic [NW-1:0]   in_am, in_bm;
	logic [1:0]      mi_nxt;
	logic [NW-1:0]   op_a, op_b;

	assign in_as = req.a_num[NW-1];
	assign in_bs = req.b_num[NW-1];
	assign in_am = in_as ? (~req.a_num + 1'b1) : req.a_num;
	assign in_bm = in_bs ? (~req.b_num + 1'b1) : req.b_num;

	always_comb begin
		in_err = (req.a_den == '0);
		case (req.kind)
			ratu_pkg::KIND_ADD, ratu_pkg::KIND_SUB, ratu_pkg::KIND_MUL:
				in_err = in_err || (req.b_den == '0);
			ratu_pkg::KIND_DIV:
				in_err = in_err || (req.b_den == '0) || (in_bm == '0);
			default: ;
		endcase
	end

	assign is_addsub = (kind_q == ratu_pkg::KIND_ADD) || (kind_q == ratu_pkg::KIND_SUB);
	assign last_mul  = is_addsub ? (mi_q == 2'd2) : (mi_q == 2'd1);
	assign mi_nxt    = mi_q + 2'd1;
	assign sb_eff    = (kind_q == ratu_pkg::KIND_SUB) ? !bs_q : bs_q;

	// product operands by operation and product index
	function automatic logic [2*NW-1:0] mul_ops(
		input logic [2:0] k, input logic [1:0] i,
		input logic [NW-1:0] am, input logic [NW-1:0] bm,
		input logic [DW-1:0] ad, input logic [DW-1:0] bd);
		logic [NW-1:0] ade, bde;
		logic [2*NW-1:0] r;
		ade = {1'b0, ad};
		bde = {1'b0, bd};
		r   = {ade, bde};
		case (k)
			ratu_pkg::KIND_ADD, ratu_pkg::KIND_SUB: begin
				if (i == 2'd0)      r = {am, bde};
				else if (i == 2'd1) r = {bm, ade};
				else                r = {ade, bde};
			end
			ratu_pkg::KIND_MUL: r = (i == 2'd0) ? {am, bm} : {ade, bde};
			ratu_pkg::KIND_DIV: r = (i == 2'd0) ? {am, bde} : {ade, bm};
			default: r = {ade, bde};
		endcase
		return r;
	endfunction

	always_comb begin
		{op_a, op_b} = mul_ops(kind_q, mi_nxt, am_q, bm_q, ad_q, bd_q);
	end

	assign ovf = (rs_q ? (rm_q > LIM) : (rm_q > LIM - 1'b1)) || (rd_q > LIM - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			gcd_go_q <= 1'b0;
			div_go_q <= 1'b0;
			mi_q     <= '0;
		end else begin
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			gcd_go_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (in_err) begin
							rsp_q   <= '{res_num: '0, res_den: DW'(1),
							             status: ratu_pkg::STAT_DIVZ};
							done_q  <= 1'b1;
						end else if (req.kind <= ratu_pkg::KIND_DIV) begin
							{mul_a_q, mul_b_q} <= mul_ops(req.kind, 2'd0, in_am, in_bm,
							                              req.a_den, req.b_den);
							mul_go_q <= 1'b1;
							mi_q     <= '0;
							state_q  <= S_MUL;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						if (last_mul) begin
							state_q <= is_addsub ? S_ADD : S_RED;
						end else begin
							mul_a_q  <= op_a;
							mul_b_q  <= op_b;
							mul_go_q <= 1'b1;
							mi_q     <= mi_nxt;
						end
					end
				end
				S_ADD: state_q <= S_RED;
				S_RED: begin
					if (rm_q == '0) begin
						state_q <= S_CHECK;
					end else begin
						gcd_go_q <= 1'b1;
						state_q  <= S_GCD;
					end
				end
				S_GCD: begin
					if (gcd_done) begin
						div_n_q  <= gcd_mx;
						div_d_q  <= gcd_g;
						div_go_q <= 1'b1;
						state_q  <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						div_n_q  <= gcd_my;
						div_d_q  <= gcd_g;
						div_go_q <= 1'b1;
						state_q  <= S_DIV2;
					end
				end
				S_DIV2: if (div_done) state_q <= S_CHECK;
				S_CHECK: begin
					if (ovf) begin
						rsp_q <= '{res_num: '0, res_den: DW'(1), status: ratu_pkg::STAT_OVF};
					end else begin
						rsp_q <= '{res_num: rs_q ? (~rm_q[NW-1:0] + 1'b1) : rm_q[NW-1:0],
						           res_den: rd_q[DW-1:0], status: ratu_pkg::STAT_OK};
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand and intermediate registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q <= req.kind;
					as_q   <= in_as;
					bs_q   <= in_bs;
					am_q   <= in_am;
					bm_q   <= in_bm;
					ad_q   <= req.a_den;
					bd_q   <= req.b_den;
					rs_q   <= (req.kind == ratu_pkg::KIND_NEG) ? !in_as : in_as;
					rm_q   <= MW'(in_am);
					rd_q   <= MW'(req.a_den);
					if (req.kind == ratu_pkg::KIND_MUL || req.kind == ratu_pkg::KIND_DIV)
						rs_q <= in_as != in_bs;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					if (mi_q == 2'd0)             rm_q <= mul_p;
					else if (is_addsub && mi_q == 2'd1) p1_q <= mul_p;
					else                          rd_q <= mul_p;
				end
			end
			S_ADD: begin
				if (as_q == sb_eff) begin
					rm_q <= rm_q + p1_q;
				end else if (rm_q >= p1_q) begin
					rm_q <= rm_q - p1_q;
				end else begin
					rs_q <= sb_eff;
					rm_q <= p1_q - rm_q;
				end
			end
			S_RED: begin
				if (rm_q == '0) begin
					rs_q <= 1'b0;
					rd_q <= MW'(1);
				end
			end
			S_DIV1: if (div_done) rm_q <= div_q;
			S_DIV2: if (div_done) rd_q <= div_q;
			default: ;
		endcase
	end

	ratu_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .p(mul_p)
	);

	ratu_gcd u_gcd (
		.clk(clk), .arst_n(arst_n), .go(gcd_go_q), .x(rm_q), .y(rd_q),
		.done(gcd_done), .g(gcd_g), .mx(gcd_mx), .my(gcd_my)
	);

	ratu_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .dividend(div_n_q), .divisor(div_d_q),
		.done(div_done), .q(div_q)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

[rtl/ratu_checker.sv]
// Port-level checks for rational_arith_unit, bound to the top level.
// Uses ratu_pkg and rational_arith_unit_assert.svh.
`default_nettype none
`include "rational_arith_unit_assert.svh"
module ratu_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire ratu_pkg::ratu_out_t rsp
);
	`RATU_AP_IMP(a_err_word, done && rsp.status != ratu_pkg::STAT_OK, rsp.res_num == '0 && rsp.res_den == 31'd1, "error word not 0/1")
	`RATU_AP_IMP(a_den_pos, done, rsp.res_den != '0, "zero denominator on result")
	`RATU_AP_IMP(a_zero_canon, done && rsp.res_num == '0, rsp.res_den == 31'd1, "zero result not 0/1")
	`RATU_AP_NXT(a_accept_next, start && !busy, busy || done, "accepted word neither busy nor answered")
	`RATU_AP_IMP(a_stat_code, done, rsp.status == ratu_pkg::STAT_OK || rsp.status == ratu_pkg::STAT_DIVZ || rsp.status == ratu_pkg::STAT_OVF, "bad status code")
endmodule

bind rational_arith_unit ratu_checker u_ratu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire

[tb/tb.sv]
// Testbench for rational_arith_unit: directed and random rational operations,
// predicted in place and checked word by word. Depends on ratu_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ratu_pkg::ratu_in_t req = '0;
	logic busy;
	logic done;
	ratu_pkg::ratu_out_t rsp;

	rational_arith_unit #(.OPERAND_WIDTH(32)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	ratu_pkg::ratu_in_t op_queue[$];
	ratu_pkg::ratu_out_t result_queue[$];
	int errors = 0;
	int idle_pct = 0;
	int wdog = 0;

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic ratu_pkg::ratu_out_t reduce_rational(ratu_pkg::ratu_in_t w);
		ratu_pkg::ratu_out_t r;
		logic as, bs, rs;
		logic [63:0] am, bm, rm, rd, g, x, y, lim;
		logic [1:0] st;
		as = w.a_num[31];
		bs = w.b_num[31];
		am = as ? 64'h1_0000_0000 - {32'd0, w.a_num} : {32'd0, w.a_num};
		bm = bs ? 64'h1_0000_0000 - {32'd0, w.b_num} : {32'd0, w.b_num};
		rs = 0; rm = 0; rd = 1; st = ratu_pkg::STAT_OK;
		case (w.kind)
			ratu_pkg::KIND_ADD, ratu_pkg::KIND_SUB: begin
				if (w.a_den == 0 || w.b_den == 0) st = ratu_pkg::STAT_DIVZ;
				else begin
					x = am * w.b_den;
					y = bm * w.a_den;
					if (w.kind == ratu_pkg::KIND_SUB) bs = !bs;
					if (as == bs) begin rs = as; rm = x + y; end
					else if (x >= y) begin rs = as; rm = x - y; end
					else begin rs = bs; rm = y - x; end
					rd = 64'(w.a_den) * w.b_den;
				end
			end
			ratu_pkg::KIND_MUL: begin
				if (w.a_den == 0 || w.b_den == 0) st = ratu_pkg::STAT_DIVZ;
				else begin rs = as != bs; rm = am * bm; rd = 64'(w.a_den) * w.b_den; end
			end
			ratu_pkg::KIND_DIV: begin
				if (w.a_den == 0 || w.b_den == 0 || bm == 0) st = ratu_pkg::STAT_DIVZ;
				else begin rs = as != bs; rm = am * w.b_den; rd = 64'(w.a_den) * bm; end
			end
			ratu_pkg::KIND_NEG: begin
				if (w.a_den == 0) st = ratu_pkg::STAT_DIVZ;
				else begin rs = !as; rm = am; rd = w.a_den; end
			end
			default: begin
				if (w.a_den == 0) st = ratu_pkg::STAT_DIVZ;
				else begin rs = as; rm = am; rd = w.a_den; end
			end
		endcase
		if (st == ratu_pkg::STAT_OK) begin
			if (rm == 0) begin rs = 0; rd = 1; end
			else begin g = gcd64(rm, rd); rm = rm / g; rd = rd / g; end
			lim = 64'd1 << 31;
			if ((rs ? rm > lim : rm > lim - 1) || rd > lim - 1) st = ratu_pkg::STAT_OVF;
		end
		if (st != ratu_pkg::STAT_OK) begin
			r.res_num = '0; r.res_den = 31'd1;
		end else begin
			r.res_num = rs ? 32'(0 - rm) : 32'(rm);
			r.res_den = 31'(rd);
		end
		r.status = st;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				result_queue.push_back(reduce_rational(req));
			end
			if (!(start && busy)) begin
				if (op_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					req <= op_queue.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ratu_pkg::ratu_out_t want;
		if (arst_n && done) begin
			if (result_queue.size() == 0) begin
				report_mismatch("unexpected word", 64'(rsp), 0);
			end else begin
				want = result_queue.pop_front();
				if (rsp.res_num !== want.res_num)
					report_mismatch("res_num", 64'(rsp.res_num), 64'(want.res_num));
				if (rsp.res_den !== want.res_den)
					report_mismatch("res_den", 64'(rsp.res_den), 64'(want.res_den));
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_num();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(20)) - 10);
			3: return 32'(int'($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_den();
		case ($urandom_range(6))
			0: return 31'd1;
			1: return 31'h7fff_ffff;
			2: return 31'($urandom_range(1, 12));
			3: return 31'($urandom_range(1, 5000));
			4: return ($urandom_range(40) == 0) ? 31'd0 : 31'd1;
			default: return 31'($urandom | 1);
		endcase
	endfunction

	task automatic push_op(logic [2:0] k, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		ratu_pkg::ratu_in_t w;
		w.kind = k; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
		op_queue.push_back(w);
	endtask

	task automatic drain();
		while (op_queue.size() > 0 || result_queue.size() > 0 || start)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	initial begin
		int ph;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// extremes, each kind, zero denominators, divide by zero, overflow
		push_op(ratu_pkg::KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
		push_op(ratu_pkg::KIND_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
		push_op(ratu_pkg::KIND_MUL, -32'sd3, 31'd4, 32'd8, 31'd9);
		push_op(ratu_pkg::KIND_DIV, 32'd3, 31'd4, -32'sd6, 31'd5);
		push_op(ratu_pkg::KIND_NEG, 32'd5, 31'd10, 32'd0, 31'd0);
		push_op(ratu_pkg::KIND_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd1);
		push_op(ratu_pkg::KIND_NEG, 32'h8000_0000, 31'd2, 32'd0, 31'd1);
		push_op(ratu_pkg::KIND_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
		push_op(ratu_pkg::KIND_SUB, 32'd1, 31'd1, 32'd1, 31'd0);
		push_op(ratu_pkg::KIND_MUL, 32'd1, 31'd0, 32'd1, 31'd1);
		push_op(ratu_pkg::KIND_DIV, 32'd1, 31'd1, 32'd0, 31'd1);
		push_op(ratu_pkg::KIND_DIV, 32'd1, 31'd1, 32'd2, 31'd0);
		push_op(ratu_pkg::KIND_NEG, 32'd1, 31'd0, 32'd1, 31'd1);
		push_op(ratu_pkg::KIND_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
		push_op(ratu_pkg::KIND_ADD, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
		push_op(ratu_pkg::KIND_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
			31'h7fff_ffff);
		push_op(ratu_pkg::KIND_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'd1);
		push_op(ratu_pkg::KIND_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
		push_op(ratu_pkg::KIND_ADD, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7ffffffe);
		push_op(ratu_pkg::KIND_SUB, 32'd0, 31'd5, 32'd0, 31'd7);
		push_op(3'd5, 32'd6, 31'd4, 32'd0, 31'd0);
		push_op(3'd6, 32'h8000_0000, 31'd0, 32'd1, 31'd1);
		push_op(3'd7, -32'sd9, 31'd3, 32'd1, 31'd1);
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 58 : (ph == 3) ? 38 : 0;
			for (int i = 0; i < 300; i++) begin
				push_op(($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(4)),
					pick_num(), pick_den(), pick_num(), pick_den());
			end
			drain();
		end
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/ratu_pkg.sv
rtl/ratu_mul.sv
rtl/ratu_gcd.sv
rtl/ratu_div.sv
rtl/rational_arith_unit.sv
rtl/ratu_checker.sv
tb/tb.sv
